### rtl/cstrip_pkg.sv
// ----------------------------------------------------------------------------
// cstrip_pkg
// Shared constants and types for the comment stripper.
// ----------------------------------------------------------------------------
package cstrip_pkg;

    localparam int CHAR_BITS = 8;
    localparam int LINE_BITS = 32;

    localparam int IN_DATA_W  = ((CHAR_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((CHAR_BITS + 2 + LINE_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - CHAR_BITS - 2 - LINE_BITS;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_BITS-1:0] C_NL    = CHAR_BITS'(10);
    localparam logic [CHAR_BITS-1:0] C_QUOTE = CHAR_BITS'(34);
    localparam logic [CHAR_BITS-1:0] C_SLASH = CHAR_BITS'(47);
    localparam logic [CHAR_BITS-1:0] C_STAR  = CHAR_BITS'(42);
    localparam logic [CHAR_BITS-1:0] C_SPACE = CHAR_BITS'(32);

    typedef enum logic [3:0] {
        MODE_NONE  = 4'b0001,
        MODE_LINE  = 4'b0010,
        MODE_BLOCK = 4'b0100,
        MODE_STR   = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OPEN_CMT  = 2'd1,
        ST_OPEN_STR  = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 valid;
        logic                 eot;
        logic [1:0]           status;
        logic [LINE_BITS-1:0] eline;
    } result_t;

endpackage

### rtl/comment_stripper.sv
// ----------------------------------------------------------------------------
// comment_stripper
// Streaming C-style comment stripper with line tracking and end status.
// ----------------------------------------------------------------------------
// Input channel s_axis: one character per word, tlast marks the final
// character of a text. Output channel m_axis: zero to two words per input
// character (at least one for a final character); tuser high when tdata
// carries a character, tlast high on the closing word of a text, which also
// carries the status and the line where an open comment or string began.
// Each character is decoded in the cycle it is accepted and its words are
// written into a four-entry output queue, whose head drives m_axis
// combinationally. One character per cycle is taken while the queue has room
// for two words, so plain text flows at one word per cycle while the receiver
// is ready; a block-comment opener yields two words.
// When the receiver stalls the queue fills and s_axis_tready drops.
// Reset clears the decode state (line count back to 1) and empties the
// queue. After a final character the decode state returns to its reset value.
// ----------------------------------------------------------------------------
module comment_stripper
    import cstrip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // in_char
    input  logic                  s_axis_tlast,   // last_char
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_char, status, error_line
    output logic                  m_axis_tuser,   // char_valid
    output logic                  m_axis_tlast    // end_of_text
);

    mode_t                mode_reg, mode_next;
    logic                 slash_reg, slash_next;
    logic                 star_reg, star_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] start_reg, start_next;

    result_t              fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    logic [CHAR_BITS-1:0] c;
    logic                 last;
    logic                 accept, pop;
    logic [1:0]           n;
    result_t              r0, r1;
    logic [1:0]           st;
    logic [PTR_W-1:0]     wr_ptr_p1;

    assign c      = s_axis_tdata[CHAR_BITS-1:0];
    assign last   = s_axis_tlast;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        logic plain;
        plain      = 1'b1;
        n          = 2'd0;
        r0         = '0;
        r1         = '0;
        st         = ST_OK;
        mode_next  = mode_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        start_next = start_reg;
        line_next  = (c == C_NL) ? line_reg + LINE_BITS'(1) : line_reg;

        case (mode_reg)
            MODE_NONE:
            begin
                if (slash_reg)
                begin
                    slash_next = 1'b0;
                    if (c == C_SLASH)
                    begin
                        mode_next = MODE_LINE;
                        plain     = 1'b0;
                    end
                    else if (c == C_STAR)
                    begin
                        mode_next  = MODE_BLOCK;
                        star_next  = 1'b0;
                        start_next = line_reg;
                        r0.ch      = C_SPACE;
                        r0.valid   = 1'b1;
                        r1.ch      = C_SPACE;
                        r1.valid   = 1'b1;
                        n          = 2'd2;
                        plain      = 1'b0;
                    end
                    else
                    begin
                        r0.ch    = C_SLASH;
                        r0.valid = 1'b1;
                        n        = 2'd1;
                    end
                end
                if (plain)
                begin
                    if (c == C_SLASH && !last)
                    begin
                        slash_next = 1'b1;
                    end
                    else
                    begin
                        if (c == C_QUOTE)
                        begin
                            mode_next  = MODE_STR;
                            start_next = line_reg;
                        end
                        if (n == 2'd0)
                        begin
                            r0.ch    = c;
                            r0.valid = 1'b1;
                        end
                        else
                        begin
                            r1.ch    = c;
                            r1.valid = 1'b1;
                        end
                        n = n + 2'd1;
                    end
                end
            end
            MODE_LINE:
            begin
                if (c == C_NL)
                begin
                    mode_next = MODE_NONE;
                    r0.ch     = c;
                    r0.valid  = 1'b1;
                    n         = 2'd1;
                end
            end
            MODE_BLOCK:
            begin
                r0.valid = 1'b1;
                n        = 2'd1;
                if (c == C_NL)
                begin
                    star_next = 1'b0;
                    r0.ch     = c;
                end
                else if (c == C_SLASH && star_reg)
                begin
                    mode_next = MODE_NONE;
                    star_next = 1'b0;
                    r0.ch     = C_SPACE;
                end
                else
                begin
                    star_next = (c == C_STAR);
                    r0.ch     = C_SPACE;
                end
            end
            MODE_STR:
            begin
                if (c == C_QUOTE)
                begin
                    mode_next = MODE_NONE;
                end
                r0.ch    = c;
                r0.valid = 1'b1;
                n        = 2'd1;
            end
            default:
            begin
                mode_next = MODE_NONE;
            end
        endcase

        if (last)
        begin
            if (mode_next == MODE_BLOCK)
            begin
                st = ST_OPEN_CMT;
            end
            else if (mode_next == MODE_STR)
            begin
                st = ST_OPEN_STR;
            end
            if (n == 2'd0)
            begin
                n = 2'd1;
            end
            if (n == 2'd1)
            begin
                r0.eot    = 1'b1;
                r0.status = st;
                r0.eline  = (st != ST_OK) ? start_next : '0;
            end
            else
            begin
                r1.eot    = 1'b1;
                r1.status = st;
                r1.eline  = (st != ST_OK) ? start_next : '0;
            end
            mode_next  = MODE_NONE;
            slash_next = 1'b0;
            star_next  = 1'b0;
            line_next  = LINE_BITS'(1);
            start_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
            line_reg  <= LINE_BITS'(1);
            start_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
            line_reg  <= line_next;
            start_reg <= start_next;
        end
    end

    // output queue
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (n != 2'd0)
            begin
                fifo_mem[wr_ptr_reg] <= r0;
            end
            if (n == 2'd2)
            begin
                fifo_mem[wr_ptr_p1] <= r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? CNT_W'(n) : CNT_W'(0))
                         - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    result_t head;
    assign head          = fifo_mem[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {OUT_PAD_W'(0), head.eline, head.status, head.ch};
    assign m_axis_tuser  = head.valid;
    assign m_axis_tlast  = head.eot;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue count out of range");

    a_final_returns_reset: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> mode_reg == MODE_NONE && !slash_reg
                           && line_reg == LINE_BITS'(1))
        else $error("state not cleared after final character");

    a_final_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |-> n != 2'd0)
        else $error("final character produced no word");

    a_slash_only_outside: assert property (@(posedge clk) disable iff (!rst_n)
        slash_reg |-> mode_reg == MODE_NONE)
        else $error("held slash outside plain text");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> count_reg <= CNT_W'(FIFO_DEPTH - 2))
        else $error("input taken without room for two words");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the comment stripper. Characters go in on s_axis;
// a scoreboard tracks the comment/string state of each text and queues the
// expected output words, which are checked in order as m_axis delivers them.
// A short directed set covers the corner cases. Random texts built from
// comments, strings, slashes and noise follow, under several sender and
// receiver idling patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import cstrip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    class strip_scoreboard;
        mode_t                mode;
        logic                 slash_held;
        logic                 star_seen;
        logic [LINE_BITS-1:0] line_count;
        logic [LINE_BITS-1:0] start_line;
        result_t              expected_words[$];
        int                   errors;

        function new();
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            mode       = MODE_NONE;
            slash_held = 1'b0;
            star_seen  = 1'b0;
            line_count = LINE_BITS'(1);
            start_line = '0;
        endfunction

        function result_t char_word(logic [CHAR_BITS-1:0] c);
            result_t w;
            w       = '0;
            w.ch    = c;
            w.valid = 1'b1;
            return w;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_char(logic [CHAR_BITS-1:0] c, logic last);
            result_t words[$];
            result_t tail;
            logic    plain;
            plain = 1'b1;
            case (mode)
                MODE_NONE:
                begin
                    if (slash_held)
                    begin
                        slash_held = 1'b0;
                        if (c == C_SLASH)
                        begin
                            mode  = MODE_LINE;
                            plain = 1'b0;
                        end
                        else if (c == C_STAR)
                        begin
                            mode       = MODE_BLOCK;
                            star_seen  = 1'b0;
                            start_line = line_count;
                            words.push_back(char_word(C_SPACE));
                            words.push_back(char_word(C_SPACE));
                            plain = 1'b0;
                        end
                        else
                            words.push_back(char_word(C_SLASH));
                    end
                    if (plain)
                    begin
                        if (c == C_SLASH)
                        begin
                            if (last)
                                words.push_back(char_word(c));
                            else
                                slash_held = 1'b1;
                        end
                        else
                        begin
                            if (c == C_QUOTE)
                            begin
                                mode       = MODE_STR;
                                start_line = line_count;
                            end
                            else if (c == C_NL)
                                line_count = line_count + 1'b1;
                            words.push_back(char_word(c));
                        end
                    end
                end
                MODE_LINE:
                begin
                    if (c == C_NL)
                    begin
                        line_count = line_count + 1'b1;
                        mode       = MODE_NONE;
                        words.push_back(char_word(c));
                    end
                end
                MODE_BLOCK:
                begin
                    if (c == C_NL)
                    begin
                        line_count = line_count + 1'b1;
                        star_seen  = 1'b0;
                        words.push_back(char_word(c));
                    end
                    else if (c == C_SLASH && star_seen)
                    begin
                        mode      = MODE_NONE;
                        star_seen = 1'b0;
                        words.push_back(char_word(C_SPACE));
                    end
                    else
                    begin
                        star_seen = (c == C_STAR);
                        words.push_back(char_word(C_SPACE));
                    end
                end
                default:
                begin
                    if (c == C_QUOTE)
                        mode = MODE_NONE;
                    else if (c == C_NL)
                        line_count = line_count + 1'b1;
                    words.push_back(char_word(c));
                end
            endcase

            if (last)
            begin
                if (words.size() == 0)
                begin
                    tail = '0;
                    words.push_back(tail);
                end
                tail     = words.pop_back();
                tail.eot = 1'b1;
                if (mode == MODE_BLOCK)
                    tail.status = ST_OPEN_CMT;
                else if (mode == MODE_STR)
                    tail.status = ST_OPEN_STR;
                else
                    tail.status = ST_OK;
                tail.eline = (tail.status != ST_OK) ? start_line : '0;
                words.push_back(tail);
                clear_text();
            end

            foreach (words[i])
                expected_words.push_back(words[i]);
        endfunction

        function void compare_field(string field, logic [63:0] want,
                                    logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $display({"%0t: unexpected word, expected none, ",
                          "actual ch=%0h valid=%0b last=%0b st=%0d line=%0d"},
                         $time, got.ch, got.valid, got.eot, got.status, got.eline);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("out_char", 64'(want.ch), 64'(got.ch));
            compare_field("char_valid", 64'(want.valid), 64'(got.valid));
            compare_field("end_of_text", 64'(want.eot), 64'(got.eot));
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("error_line", 64'(want.eline), 64'(got.eline));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    result_t         out_word;
    strip_scoreboard board;
    int              sender_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              hold_len = 0;
    int unsigned     cycle_count = 0;

    comment_stripper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    assign out_word = {m_axis_tdata[CHAR_BITS-1:0], m_axis_tuser, m_axis_tlast,
                       m_axis_tdata[CHAR_BITS+1:CHAR_BITS],
                       m_axis_tdata[CHAR_BITS+LINE_BITS+1:CHAR_BITS+2]};

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_char(s_axis_tdata[CHAR_BITS-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(out_word);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_len--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] body_char();
        case ($urandom_range(0, 9))
            0:       return C_STAR;
            1:       return C_SLASH;
            2:       return C_NL;
            3:       return C_QUOTE;
            default: return 8'($urandom_range(8'h20, 8'h7e));
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(c);
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic run_random(input int n_chars, input int idle, input int stall);
        logic [7:0] text[$];
        int         sent;
        int         len;
        sender_idle_pct = idle;
        recv_stall_pct  = stall;
        sent = 0;
        while (sent < n_chars)
        begin
            text.delete();
            repeat ($urandom_range(1, 6))
            begin
                len = $urandom_range(0, 5);
                case ($urandom_range(0, 9))
                    0, 1:
                        repeat (len + 1)
                            text.push_back(8'($urandom_range(8'h61, 8'h7a)));
                    2:
                        text.push_back(C_NL);
                    3:
                    begin
                        text.push_back(C_SLASH);
                        text.push_back(C_SLASH);
                        repeat (len)
                            text.push_back(body_char());
                        if ($urandom_range(0, 3) != 0)
                            text.push_back(C_NL);
                    end
                    4, 5:
                    begin
                        text.push_back(C_SLASH);
                        text.push_back(C_STAR);
                        repeat (len)
                            text.push_back(body_char());
                        if ($urandom_range(0, 3) != 0)
                        begin
                            text.push_back(C_STAR);
                            text.push_back(C_SLASH);
                        end
                    end
                    6:
                    begin
                        text.push_back(C_QUOTE);
                        repeat (len)
                            text.push_back(body_char());
                        if ($urandom_range(0, 3) != 0)
                            text.push_back(C_QUOTE);
                    end
                    7:
                    begin
                        text.push_back(C_SLASH);
                        text.push_back(body_char());
                    end
                    default:
                        repeat (len + 1)
                            text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            foreach (text[i])
                send_char(text[i], i == text.size() - 1);
            sent += text.size();
        end
        drain();
    endtask

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("a/b");
        send_text("/");
        send_text("//x");
        send_text("/**/\n");
        send_text("\"/*\n");
        send_text("\n/*x");
        send_text("\"a\"");
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
        drain();

        // receiver holds off first so the output queue fills and input stalls
        hold_len = 60;
        run_random(125, 0, 0);
        run_random(125, 75, 0);
        run_random(125, 0, 75);
        run_random(125, 38, 38);

        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/cstrip_pkg.sv
rtl/comment_stripper.sv
tb/tb_top.sv
